// ===== design/spbpm_pkg.sv =====
`timescale 1ns / 1ps

package spbpm_pkg;

    localparam int SAMPLE_W = 16;
    localparam int COEF_W   = 9;
    localparam int ADDR_W   = 2;
    localparam int DIFF_W   = SAMPLE_W + 2;
    localparam int SUM_W    = DIFF_W + COEF_W + 1;

    localparam logic [COEF_W-1:0] COEF_ONE = COEF_W'(256);

    typedef enum logic [ADDR_W-1:0] {
        REG_MIN_FREQ = 2'd0,
        REG_MAX_FREQ = 2'd1,
        REG_WET_MIX  = 2'd2
    } t_reg_idx;

    typedef enum logic [1:0] {
        STEP_LOW   = 2'd0,
        STEP_INNER = 2'd1,
        STEP_MIX   = 2'd2
    } t_step;

    typedef struct packed {
        logic  load_in;
        logic  step_en;
        t_step step;
        logic  load_out;
    } t_cmd;

endpackage

// ===== design/spbpm_ctrl.sv =====
`timescale 1ns / 1ps

module spbpm_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output spbpm_pkg::t_cmd   o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOW,
        S_INNER,
        S_MIX
    } t_state;

    t_state r_state;
    logic   r_in_ready;
    logic   r_out_valid;
    logic   out_free;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_in_ready  = r_in_ready;
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd          = '0;
        o_cmd.step     = spbpm_pkg::STEP_MIX;
        case (r_state)
            S_IDLE: begin
                o_cmd.load_in = i_in_valid && r_in_ready;
            end
            S_LOW: begin
                o_cmd.step_en = 1'b1;
                o_cmd.step    = spbpm_pkg::STEP_LOW;
            end
            S_INNER: begin
                o_cmd.step_en = 1'b1;
                o_cmd.step    = spbpm_pkg::STEP_INNER;
            end
            S_MIX: begin
                o_cmd.step_en  = 1'b1;
                o_cmd.step     = spbpm_pkg::STEP_MIX;
                o_cmd.load_out = out_free;
            end
            default: begin
                o_cmd.step = spbpm_pkg::STEP_MIX;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_in_ready  <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            if (o_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid && r_in_ready) begin
                        r_state    <= S_LOW;
                        r_in_ready <= 1'b0;
                    end
                end
                S_LOW: begin
                    r_state <= S_INNER;
                end
                S_INNER: begin
                    r_state <= S_MIX;
                end
                S_MIX: begin
                    if (out_free) begin
                        r_state    <= S_IDLE;
                        r_in_ready <= 1'b1;
                    end
                end
                default: begin
                    r_state    <= S_IDLE;
                    r_in_ready <= 1'b1;
                end
            endcase
        end
    end

endmodule

// ===== design/spbpm_dp.sv =====
`timescale 1ns / 1ps

module spbpm_dp (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [spbpm_pkg::ADDR_W-1:0]           i_cfg_addr,
    input  logic [spbpm_pkg::COEF_W-1:0]           i_cfg_wdata,
    input  logic signed [spbpm_pkg::SAMPLE_W-1:0]  i_sample_in,
    input  logic                                   i_channel,
    input  spbpm_pkg::t_cmd                        i_cmd,
    output logic signed [spbpm_pkg::SAMPLE_W-1:0]  o_sample_out
);

    logic [spbpm_pkg::COEF_W-1:0]          r_min_freq;
    logic [spbpm_pkg::COEF_W-1:0]          r_max_freq;
    logic [spbpm_pkg::COEF_W-1:0]          r_wet_mix;
    logic [spbpm_pkg::COEF_W-1:0]          cfg_clamped;

    logic signed [spbpm_pkg::SAMPLE_W-1:0] r_lp_in  [2];
    logic signed [spbpm_pkg::SAMPLE_W-1:0] r_lp_out [2];
    logic signed [spbpm_pkg::SAMPLE_W-1:0] r_hp_in  [2];
    logic signed [spbpm_pkg::SAMPLE_W-1:0] r_hp_lp  [2];

    logic signed [spbpm_pkg::SAMPLE_W-1:0] r_sample;
    logic                                  r_ch;
    logic signed [spbpm_pkg::SAMPLE_W-1:0] r_low;
    logic signed [spbpm_pkg::SAMPLE_W-1:0] r_inner;
    logic signed [spbpm_pkg::SAMPLE_W-1:0] r_sample_out;

    logic signed [spbpm_pkg::DIFF_W-1:0]   op_x;
    logic signed [spbpm_pkg::DIFF_W-1:0]   op_y;
    logic [spbpm_pkg::COEF_W-1:0]          op_f;
    logic signed [spbpm_pkg::DIFF_W-1:0]   diff;
    logic signed [spbpm_pkg::SUM_W-1:0]    prod;
    logic signed [spbpm_pkg::SUM_W-1:0]    base;
    logic signed [spbpm_pkg::SUM_W-1:0]    sum;
    logic signed [spbpm_pkg::SUM_W-1:0]    rnd;
    logic signed [spbpm_pkg::SAMPLE_W-1:0] quot;

    assign cfg_clamped = (i_cfg_wdata > spbpm_pkg::COEF_ONE) ? spbpm_pkg::COEF_ONE
                                                             : i_cfg_wdata;

    always_comb begin
        case (i_cmd.step)
            spbpm_pkg::STEP_LOW: begin
                op_x = spbpm_pkg::DIFF_W'(r_lp_in[r_ch]);
                op_y = spbpm_pkg::DIFF_W'(r_lp_out[r_ch]);
                op_f = r_max_freq;
            end
            spbpm_pkg::STEP_INNER: begin
                op_x = spbpm_pkg::DIFF_W'(r_hp_in[r_ch]);
                op_y = spbpm_pkg::DIFF_W'(r_hp_lp[r_ch]);
                op_f = r_min_freq;
            end
            default: begin
                op_x = spbpm_pkg::DIFF_W'(r_low) - spbpm_pkg::DIFF_W'(r_inner);
                op_y = spbpm_pkg::DIFF_W'(r_sample);
                op_f = r_wet_mix;
            end
        endcase
    end

    // x*f + y*(256-f) == y*256 + (x-y)*f, then divide by 256 toward zero
    assign diff = op_x - op_y;
    assign prod = spbpm_pkg::SUM_W'(diff) * spbpm_pkg::SUM_W'($signed({1'b0, op_f}));
    assign base = spbpm_pkg::SUM_W'(op_y) <<< 8;
    assign sum  = base + prod;
    assign rnd  = sum + (sum[spbpm_pkg::SUM_W-1] ? spbpm_pkg::SUM_W'(255)
                                                  : spbpm_pkg::SUM_W'(0));
    assign quot = rnd[spbpm_pkg::SAMPLE_W+7:8];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_freq <= '0;
            r_max_freq <= '0;
            r_wet_mix  <= '0;
            for (int c = 0; c < 2; c++) begin
                r_lp_in[c]  <= '0;
                r_lp_out[c] <= '0;
                r_hp_in[c]  <= '0;
                r_hp_lp[c]  <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                case (spbpm_pkg::t_reg_idx'(i_cfg_addr))
                    spbpm_pkg::REG_MIN_FREQ: r_min_freq <= cfg_clamped;
                    spbpm_pkg::REG_MAX_FREQ: r_max_freq <= cfg_clamped;
                    spbpm_pkg::REG_WET_MIX:  r_wet_mix  <= cfg_clamped;
                    default: begin
                    end
                endcase
            end
            if (i_cmd.step_en) begin
                case (i_cmd.step)
                    spbpm_pkg::STEP_LOW: begin
                        r_lp_out[r_ch] <= quot;
                        r_lp_in[r_ch]  <= r_sample;
                    end
                    spbpm_pkg::STEP_INNER: begin
                        r_hp_lp[r_ch] <= quot;
                        r_hp_in[r_ch] <= r_low;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_sample <= i_sample_in;
            r_ch     <= i_channel;
        end
        if (i_cmd.step_en && i_cmd.step == spbpm_pkg::STEP_LOW) begin
            r_low <= quot;
        end
        if (i_cmd.step_en && i_cmd.step == spbpm_pkg::STEP_INNER) begin
            r_inner <= quot;
        end
        if (i_cmd.load_out) begin
            r_sample_out <= quot;
        end
    end

    assign o_sample_out = r_sample_out;

endmodule

// ===== design/stereo_one_pole_band_pass_mix.sv =====
`timescale 1ns / 1ps
// Channel   Handshake                 Beat payload
// input     i_in_valid / o_in_ready   i_sample_in[15:0] signed, i_channel
// output    o_out_valid / i_out_ready o_sample_out[15:0] signed
// config    i_cfg_we (no wait)        i_cfg_addr[1:0], i_cfg_wdata[8:0]
//
// Beats are processed one at a time: accept, then low-pass, inner low-pass and mix steps,
// one state each, through a single shared 18x10 multiplier; no new beat is taken before mix.
// The output register frees the input side: a new beat is taken while a result waits.
// A stalled output holds the mix step until the result register is free.
// Synchronous active-low reset clears config, filter state and output valid, and sets input ready.
module stereo_one_pole_band_pass_mix (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [spbpm_pkg::ADDR_W-1:0]           i_cfg_addr,
    input  logic [spbpm_pkg::COEF_W-1:0]           i_cfg_wdata,
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  logic signed [spbpm_pkg::SAMPLE_W-1:0]  i_sample_in,
    input  logic                                   i_channel,
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic signed [spbpm_pkg::SAMPLE_W-1:0]  o_sample_out
);

    spbpm_pkg::t_cmd cmd;

    spbpm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd)
    );

    spbpm_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_sample_in  (i_sample_in),
        .i_channel    (i_channel),
        .i_cmd        (cmd),
        .o_sample_out (o_sample_out)
    );

endmodule

// ===== design/spbpm_checker.sv =====
`timescale 1ns / 1ps

module spbpm_checker (
    input logic                                  i_clk,
    input logic                                  i_rst_n,
    input logic                                  i_in_valid,
    input logic                                  o_in_ready,
    input logic                                  o_out_valid,
    input logic                                  i_out_ready,
    input logic signed [spbpm_pkg::SAMPLE_W-1:0] o_sample_out
);

    a_out_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("output valid dropped before beat taken");

    a_out_data_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_sample_out))
        else $error("output payload changed while stalled");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready ##1 !o_in_ready ##1 !o_in_ready)
        else $error("input ready returned before three steps done");

    a_result_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(i_in_valid && o_in_ready, 4))
        else $error("result appeared without a beat four cycles earlier");

endmodule

bind stereo_one_pole_band_pass_mix spbpm_checker u_spbpm_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_ready   (o_in_ready),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_sample_out (o_sample_out)
);
